// ===== rtl/core/atrp_pkg.sv =====
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants for the accelerometer tilt block
// Field widths, fixed-point formats, the arctangent table and the stage
// records that travel between the cells of the pipeline.
// ----------------------------------------------------------------------------
package atrp_pkg;

  // Sample and result fields.
  localparam int ACCEL_W = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  // Rotation stages of each vectoring chain.
  localparam int CORDIC_STAGES = 16;
  localparam int STG_W         = $clog2(CORDIC_STAGES);

  // Square root of (y^2 + z^2) * 2^32, one result bit per cell.
  localparam int SSQ_W      = 32;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int WORK_W     = ROOT_W + 4;

  // Vector components are counts scaled by 2^24; the root is Q16 scaled by 2^8.
  localparam int DATA_SHIFT = 24;
  localparam int ROOT_SHIFT = 8;
  localparam int DATA_W     = 44;

  // Angles are radians in Q30.
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] PI_Q30   = 34'sd3373259426;
  localparam logic [63:0]             PI_Q30_U = 64'd3373259426;

  // Radians Q30 to degrees * 128: multiply by the scale, round at bit 48.
  localparam int          DEG_FRAC       = 48;
  localparam logic [63:0] DEG_SCALE_FULL =
    ((64'd23040 << DEG_FRAC) + PI_Q30_U / 2) / PI_Q30_U;
  localparam int                 SCALE_W   = 31;
  localparam logic [SCALE_W-1:0] DEG_SCALE = DEG_SCALE_FULL[SCALE_W-1:0];
  localparam int                 MUL_W     = ANG_W + SCALE_W;
  localparam int                 DEG_W     = MUL_W - DEG_FRAC + 1;
  localparam logic [MUL_W:0]     ROUND_ADD =
    {{(MUL_W - DEG_FRAC + 1){1'b0}}, 1'b1, {(DEG_FRAC - 1){1'b0}}};

  localparam int ROLL_LIM  = 23040;
  localparam int PITCH_LIM = 11520;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } accel_t;

  typedef struct packed {
    logic [SSQ_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    accel_t            acc;
  } sqrt_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ANG_W-1:0]  ang;
  } vec_t;

  typedef struct packed {
    vec_t roll;
    vec_t pitch;
    logic roll_zero;
    logic pitch_zero;
  } cordic_t;

  // atan(2^-i) in radians, Q30, rounded to nearest.
  function automatic logic [ANG_W-1:0] atan_q30(input int unsigned idx);
    logic [ANG_W-1:0] val;
    case (idx)
      0:       val = 34'd843314857;
      1:       val = 34'd497837829;
      2:       val = 34'd263043837;
      3:       val = 34'd133525159;
      4:       val = 34'd67021687;
      5:       val = 34'd33543516;
      6:       val = 34'd16775851;
      7:       val = 34'd8388437;
      8:       val = 34'd4194283;
      9:       val = 34'd2097149;
      default: val = ANG_W'(34'd1 << (30 - idx));
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/atrp_sample_if.sv =====
// ----------------------------------------------------------------------------
// atrp_sample_if: request channel carrying one three-axis sample
// Valid/ready handshake with the raw signed acceleration counts.
// ----------------------------------------------------------------------------
interface atrp_sample_if import atrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

// ===== rtl/core/atrp_tilt_if.sv =====
// ----------------------------------------------------------------------------
// atrp_tilt_if: request channel carrying one roll/pitch result
// Valid/ready handshake with both angles in degrees times 128.
// ----------------------------------------------------------------------------
interface atrp_tilt_if import atrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// ===== rtl/core/accel_tilt_roll_pitch.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from one accelerometer sample
// Fully pipelined fixed-point atan2 for roll and pitch, in degrees * 128.
// ----------------------------------------------------------------------------
// Usage:
//   The sample channel takes one request per cycle while the receiver
//   keeps up, carrying the raw signed X, Y and Z counts. The tilt channel
//   returns one request per sample, in order, with roll = atan2(y, z) and
//   pitch = atan2(-x, sqrt(y^2 + z^2)), both in degrees with 7 fraction
//   bits, rounded to nearest. The pipeline is a squaring register and a
//   summing register, 32 square root cells that each settle one root bit,
//   one rotation cell per CORDIC stage, and the degree conversion's
//   magnitude, multiply and rounding registers, the last being the output
//   register. Throughput is one sample per cycle while the receiver keeps up;
//   the chain of cells sets it, each cell passing its work on unless held.
//   Reset clears every valid bit, so the pipeline comes up empty and ready.
//   When the receiver stalls, the result waits in the output register and
//   each cell holds only if the one after it is full, so empty slots close
//   up and samples keep entering until the whole chain is occupied.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch import atrp_pkg::*; (
  input logic         clk,
  input logic         rst,
  atrp_sample_if.sink sample,
  atrp_tilt_if.source tilt
);

  accel_t  sample_data;
  sqrt_t   sq_d [SQRT_STEPS+1];
  logic    sq_v [SQRT_STEPS+1];
  logic    sq_r [SQRT_STEPS+1];
  cordic_t cd_d [CORDIC_STAGES+1];
  logic    cd_v [CORDIC_STAGES+1];
  logic    cd_r [CORDIC_STAGES+1];

  // Sign-extend a 17-bit count and scale it by 2^24 for the vectoring chain.
  function automatic logic signed [DATA_W-1:0] scale_in(
      input logic signed [ACCEL_W:0] v);
    return {{(DATA_W - ACCEL_W - 1 - DATA_SHIFT){v[ACCEL_W]}}, v,
            {DATA_SHIFT{1'b0}}};
  endfunction

  assign sample_data.x = sample.accel_x;
  assign sample_data.y = sample.accel_y;
  assign sample_data.z = sample.accel_z;

  // Squares of y and z, summed into the radicand.
  atrp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_data   (sample_data),
    .out_valid (sq_v[0]),
    .out_ready (sq_r[0]),
    .out_data  (sq_d[0])
  );

  // Floor square root of (y^2 + z^2) * 2^32, one root bit per cell. The raw
  // sample rides along so that both angle chains can start together.
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    atrp_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[s]),
      .in_ready  (sq_r[s]),
      .in_data   (sq_d[s]),
      .out_valid (sq_v[s+1]),
      .out_ready (sq_r[s+1]),
      .out_data  (sq_d[s+1])
    );
  end

  // Starting vectors. Roll works on (z, y); a negative z is first turned by
  // 180 degrees, starting from +pi when y is non-negative and -pi otherwise.
  // Pitch works on (root, -x) with the root already non-negative. An all-zero
  // input vector is flagged so that the conversion forces the angle to zero.
  always_comb begin
    logic signed [ACCEL_W:0] x_ext;
    logic signed [ACCEL_W:0] y_ext;
    logic signed [ACCEL_W:0] z_ext;
    logic                    z_neg;
    logic                    y_neg;
    x_ext = {sq_d[SQRT_STEPS].acc.x[ACCEL_W-1], sq_d[SQRT_STEPS].acc.x};
    y_ext = {sq_d[SQRT_STEPS].acc.y[ACCEL_W-1], sq_d[SQRT_STEPS].acc.y};
    z_ext = {sq_d[SQRT_STEPS].acc.z[ACCEL_W-1], sq_d[SQRT_STEPS].acc.z};
    z_neg = z_ext[ACCEL_W];
    y_neg = y_ext[ACCEL_W];

    if (z_neg) begin
      cd_d[0].roll.x   = scale_in(-z_ext);
      cd_d[0].roll.y   = scale_in(-y_ext);
      cd_d[0].roll.ang = y_neg ? -PI_Q30 : PI_Q30;
    end else begin
      cd_d[0].roll.x   = scale_in(z_ext);
      cd_d[0].roll.y   = scale_in(y_ext);
      cd_d[0].roll.ang = '0;
    end

    cd_d[0].pitch.x   = {{(DATA_W - ROOT_W - ROOT_SHIFT){1'b0}},
                         sq_d[SQRT_STEPS].root, {ROOT_SHIFT{1'b0}}};
    cd_d[0].pitch.y   = scale_in(-x_ext);
    cd_d[0].pitch.ang = '0;

    cd_d[0].roll_zero  = (y_ext == '0) && (z_ext == '0);
    cd_d[0].pitch_zero = (y_ext == '0) && (z_ext == '0) && (x_ext == '0);
  end

  assign cd_v[0]          = sq_v[SQRT_STEPS];
  assign sq_r[SQRT_STEPS] = cd_r[0];

  // Vectoring chain: each cell rotates both vectors by atan(2^-i).
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    atrp_cordic_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .stage_shift (STG_W'(i)),
      .atan_step   (atan_q30(i)),
      .in_valid    (cd_v[i]),
      .in_ready    (cd_r[i]),
      .in_data     (cd_d[i]),
      .out_valid   (cd_v[i+1]),
      .out_ready   (cd_r[i+1]),
      .out_data    (cd_d[i+1])
    );
  end

  // Radians to degrees * 128; its last stage is the output register.
  atrp_deg_conv u_deg_conv (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cd_v[CORDIC_STAGES]),
    .in_ready    (cd_r[CORDIC_STAGES]),
    .in_data     (cd_d[CORDIC_STAGES]),
    .out_valid   (tilt.valid),
    .out_ready   (tilt.ready),
    .roll_angle  (tilt.roll_angle),
    .pitch_angle (tilt.pitch_angle)
  );

  // The sample side can only be refused when every stage is full and the
  // receiver is holding off the finished result.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (tilt.valid && !tilt.ready))
    else $error("sample refused while the result side is not stalled");

endmodule

// ===== rtl/core/atrp_prep.sv =====
// ----------------------------------------------------------------------------
// atrp_prep: front stages of the tilt pipeline
// Squares y and z, then sums them to seed the square root chain.
// ----------------------------------------------------------------------------
module atrp_prep import atrp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  accel_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output sqrt_t  out_data
);

  logic                      sq_vld;
  logic                      sum_vld;
  logic                      sq_ready;
  logic                      sum_ready;
  accel_t                    sq_acc;
  logic [SSQ_W-1:0]          ysq;
  logic [SSQ_W-1:0]          zsq;
  logic signed [ACCEL_W-1:0] y_in;
  logic signed [ACCEL_W-1:0] z_in;
  logic signed [2*ACCEL_W-1:0] ysq_next;
  logic signed [2*ACCEL_W-1:0] zsq_next;
  sqrt_t                     seed;

  assign sum_ready = !sum_vld || out_ready;
  assign sq_ready  = !sq_vld || sum_ready;
  assign in_ready  = sq_ready;

  always_comb begin
    y_in     = in_data.y;
    z_in     = in_data.z;
    ysq_next = (2*ACCEL_W)'(y_in) * (2*ACCEL_W)'(y_in);
    zsq_next = (2*ACCEL_W)'(z_in) * (2*ACCEL_W)'(z_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld  <= 1'b0;
      sum_vld <= 1'b0;
    end else begin
      if (sq_ready) begin
        sq_vld <= in_valid;
      end
      if (sum_ready) begin
        sum_vld <= sq_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && in_valid) begin
      sq_acc <= in_data;
      ysq    <= SSQ_W'(ysq_next);
      zsq    <= SSQ_W'(zsq_next);
    end
    if (sum_ready && sq_vld) begin
      seed.rad  <= ysq + zsq;
      seed.rem  <= '0;
      seed.root <= '0;
      seed.acc  <= sq_acc;
    end
  end

  assign out_valid = sum_vld;
  assign out_data  = seed;

endmodule

// ===== rtl/core/atrp_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// atrp_sqrt_cell: one bit of the restoring square root
// Takes the next two radicand bits, resolves one root bit and passes on.
// ----------------------------------------------------------------------------
module atrp_sqrt_cell import atrp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  sqrt_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output sqrt_t out_data
);

  logic              vld;
  sqrt_t             data;
  sqrt_t             data_next;
  logic [WORK_W-1:0] cur;
  logic [WORK_W-1:0] trial;

  always_comb begin
    cur            = {in_data.rem, in_data.rad[SSQ_W-1 -: 2]};
    trial          = {2'b00, in_data.root, 2'b01};
    data_next.acc  = in_data.acc;
    data_next.rad  = in_data.rad << 2;
    if (cur >= trial) begin
      data_next.rem  = REM_W'(cur - trial);
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = cur[REM_W-1:0];
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = data;

  // The remainder never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld |-> (data.rem <= {1'b0, data.root, 1'b0}))
    else $error("sqrt remainder exceeds twice the partial root");

endmodule

// ===== rtl/core/atrp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// atrp_cordic_cell: one vectoring rotation for the roll and pitch vectors
// Drives each vector toward the x axis and accumulates the turned angle.
// ----------------------------------------------------------------------------
module atrp_cordic_cell import atrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [STG_W-1:0] stage_shift,
  input  logic [ANG_W-1:0] atan_step,
  input  logic             in_valid,
  output logic             in_ready,
  input  cordic_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cordic_t          out_data
);

  logic    vld;
  cordic_t data;
  cordic_t data_next;

  function automatic vec_t rotate(input vec_t v, input logic [STG_W-1:0] sh,
                                  input logic [ANG_W-1:0] step);
    vec_t                     res;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] xs;
    logic signed [DATA_W-1:0] ys;
    logic signed [ANG_W-1:0]  da;
    vx = v.x;
    vy = v.y;
    xs = vx >>> sh;
    ys = vy >>> sh;
    da = $signed(step);
    if (!vy[DATA_W-1]) begin
      res.x   = vx + ys;
      res.y   = vy - xs;
      res.ang = v.ang + da;
    end else begin
      res.x   = vx - ys;
      res.y   = vy + xs;
      res.ang = v.ang - da;
    end
    return res;
  endfunction

  always_comb begin
    data_next.roll       = rotate(in_data.roll, stage_shift, atan_step);
    data_next.pitch      = rotate(in_data.pitch, stage_shift, atan_step);
    data_next.roll_zero  = in_data.roll_zero;
    data_next.pitch_zero = in_data.pitch_zero;
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = data;

  // Both vectors start in the right half plane and the x part only grows.
  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    vld |-> (!data.roll.x[DATA_W-1] && !data.pitch.x[DATA_W-1]))
    else $error("vectoring x component went negative");

endmodule

// ===== rtl/core/atrp_deg_conv.sv =====
// ----------------------------------------------------------------------------
// atrp_deg_conv: radians to degrees times 128, with the output register
// Magnitude, scale multiply, then round, clamp and restore the sign.
// ----------------------------------------------------------------------------
module atrp_deg_conv import atrp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cordic_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ROLL_W-1:0]  roll_angle,
  output logic signed [PITCH_W-1:0] pitch_angle
);

  localparam logic signed [ROLL_W-1:0]  ROLL_MAX  = ROLL_W'(ROLL_LIM);
  localparam logic signed [ROLL_W-1:0]  ROLL_MIN  = -ROLL_MAX;
  localparam logic signed [PITCH_W-1:0] PITCH_MAX = PITCH_W'(PITCH_LIM);
  localparam logic signed [PITCH_W-1:0] PITCH_MIN = -PITCH_MAX;

  logic                      a_vld;
  logic                      b_vld;
  logic                      c_vld;
  logic                      a_ready;
  logic                      b_ready;
  logic                      c_ready;
  logic [ANG_W-1:0]          roll_mag;
  logic [ANG_W-1:0]          pitch_mag;
  logic                      roll_neg;
  logic                      pitch_neg;
  logic [MUL_W-1:0]          roll_prod;
  logic [MUL_W-1:0]          pitch_prod;
  logic                      roll_neg_b;
  logic                      pitch_neg_b;
  logic [ROLL_W-1:0]         roll_res;
  logic [ROLL_W-1:0]         pitch_res;
  logic signed [ROLL_W-1:0]  roll_q;
  logic signed [PITCH_W-1:0] pitch_q;

  function automatic logic [ANG_W-1:0] ang_mag(input logic signed [ANG_W-1:0] ang,
                                               input logic zero);
    logic [ANG_W-1:0] res;
    if (zero) begin
      res = '0;
    end else if (ang[ANG_W-1]) begin
      res = ANG_W'(-ang);
    end else begin
      res = ANG_W'(ang);
    end
    return res;
  endfunction

  function automatic logic [ROLL_W-1:0] round_clamp(input logic [MUL_W-1:0] prod,
                                                    input logic [ROLL_W-1:0] lim);
    logic [MUL_W:0]    sum;
    logic [DEG_W-1:0]  d;
    logic [ROLL_W-1:0] res;
    sum = {1'b0, prod} + ROUND_ADD;
    d   = sum[MUL_W:DEG_FRAC];
    if (d > DEG_W'(lim)) begin
      res = lim;
    end else begin
      res = d[ROLL_W-1:0];
    end
    return res;
  endfunction

  assign c_ready  = !c_vld || out_ready;
  assign b_ready  = !b_vld || c_ready;
  assign a_ready  = !a_vld || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    roll_res  = round_clamp(roll_prod, ROLL_W'(ROLL_LIM));
    pitch_res = round_clamp(pitch_prod, ROLL_W'(PITCH_LIM));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld <= in_valid;
      end
      if (b_ready) begin
        b_vld <= a_vld;
      end
      if (c_ready) begin
        c_vld <= b_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      roll_mag  <= ang_mag(in_data.roll.ang, in_data.roll_zero);
      pitch_mag <= ang_mag(in_data.pitch.ang, in_data.pitch_zero);
      roll_neg  <= in_data.roll.ang[ANG_W-1] && !in_data.roll_zero;
      pitch_neg <= in_data.pitch.ang[ANG_W-1] && !in_data.pitch_zero;
    end
    if (b_ready && a_vld) begin
      roll_prod   <= MUL_W'(roll_mag) * MUL_W'(DEG_SCALE);
      pitch_prod  <= MUL_W'(pitch_mag) * MUL_W'(DEG_SCALE);
      roll_neg_b  <= roll_neg;
      pitch_neg_b <= pitch_neg;
    end
    if (c_ready && b_vld) begin
      roll_q  <= roll_neg_b ? -roll_res : roll_res;
      pitch_q <= PITCH_W'(pitch_neg_b ? -pitch_res : pitch_res);
    end
  end

  assign out_valid   = c_vld;
  assign roll_angle  = roll_q;
  assign pitch_angle = pitch_q;

  // The clamp keeps both angles inside their physical range.
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> (roll_q <= ROLL_MAX && roll_q >= ROLL_MIN))
    else $error("roll angle outside plus or minus 180 degrees");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> (pitch_q <= PITCH_MAX && pitch_q >= PITCH_MIN))
    else $error("pitch angle outside plus or minus 90 degrees");

endmodule
